// ===== src/lmac_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the address table of the accumulator machine
package lmac_pkg;

    localparam int DATA_DEPTH = 256;
    localparam int ACC_WIDTH  = 32;
    localparam int ADDR_W     = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int PC_W       = 16;
    localparam int BYTE_W     = 8;
    localparam int OUT_ACC_W  = 32;
    // queue depth, a power of two so that the pointers wrap by themselves
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    typedef enum logic [3:0] {
        OP_HLT = 4'd0,
        OP_ADD = 4'd1,
        OP_SUB = 4'd2,
        OP_STA = 4'd3,
        OP_LDA = 4'd4,
        OP_BRA = 4'd5,
        OP_BRZ = 4'd6,
        OP_BRP = 4'd7,
        OP_INP = 4'd8,
        OP_OUT = 4'd9,
        OP_ILL = 4'd10
    } t_op;

    typedef enum logic [1:0] {
        ST_RUN     = 2'd0,
        ST_HALT    = 2'd1,
        ST_ILLEGAL = 2'd2
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] arg;
        logic [BYTE_W-1:0] chr;
    } t_instr;

    typedef logic [ADDR_W-1:0] t_addr_tab [256];

    // operand byte folded onto the data memory depth, worked out at elaboration
    function automatic t_addr_tab build_addr_tab();
        t_addr_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = ADDR_W'(i % DATA_DEPTH);
        end
        return tab;
    endfunction

    localparam t_addr_tab ADDR_TAB = build_addr_tab();

endpackage

// ===== src/lmac_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
module lmac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read during write returns the old contents
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/lmac_front.sv =====
`timescale 1ns / 1ps
// front end: input handshake, opcode decode and the instruction queue
module lmac_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [lmac_pkg::BYTE_W-1:0]       i_opcode,
    input  logic [lmac_pkg::BYTE_W-1:0]       i_operand_byte,
    input  logic [lmac_pkg::BYTE_W-1:0]       i_in_char,
    output logic                              o_q_vld,
    output lmac_pkg::t_instr                  o_q_item,
    input  logic                              i_q_pop
);

    lmac_pkg::t_instr                    r_q [lmac_pkg::Q_DEPTH];
    logic [lmac_pkg::Q_PTR_W-1:0]        r_wr_ptr;
    logic [lmac_pkg::Q_PTR_W-1:0]        r_rd_ptr;
    logic [lmac_pkg::Q_CNT_W-1:0]        r_cnt;
    logic [lmac_pkg::Q_CNT_W-1:0]        n_cnt;
    logic                                push;
    lmac_pkg::t_instr                    dec;

    always_comb begin
        if (i_opcode <= lmac_pkg::BYTE_W'(lmac_pkg::OP_OUT)) begin
            dec.op = lmac_pkg::t_op'(i_opcode[3:0]);
        end else begin
            dec.op = lmac_pkg::OP_ILL;
        end
        dec.arg = i_operand_byte;
        dec.chr = i_in_char;
    end

    assign o_stall  = (r_cnt == lmac_pkg::Q_CNT_W'(lmac_pkg::Q_DEPTH));
    assign push     = i_valid && !o_stall;
    assign o_q_vld  = (r_cnt != '0);
    assign o_q_item = r_q[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_q_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_q_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec;
        end
    end

endmodule

// ===== src/lmac_back.sv =====
`timescale 1ns / 1ps
// back end: data memory read, instruction execute and the result register
module lmac_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_vld,
    input  lmac_pkg::t_instr                     i_q_item,
    output logic                                 o_q_pop,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [lmac_pkg::PC_W-1:0]            o_next_ip,
    output logic                                 o_out_valid,
    output logic [lmac_pkg::BYTE_W-1:0]          o_out_char,
    output logic [1:0]                           o_status,
    output logic [lmac_pkg::OUT_ACC_W-1:0]       o_acc_value
);

    localparam int AW = lmac_pkg::ADDR_W;
    localparam int AC = lmac_pkg::ACC_WIDTH;

    // architectural state
    logic [lmac_pkg::PC_W-1:0]          r_pc;
    logic [lmac_pkg::PC_W-1:0]          n_pc;
    logic [AC-1:0]                      r_acc;
    logic [AC-1:0]                      n_acc;
    lmac_pkg::t_status                  r_status;
    lmac_pkg::t_status                  n_status;
    logic [lmac_pkg::DATA_DEPTH-1:0]    r_vld;

    // execute stage
    logic                               r_ex_vld;
    lmac_pkg::t_instr                   r_ex;
    logic                               r_rd_vld;
    logic                               r_fwd_hit;
    logic [lmac_pkg::BYTE_W-1:0]        r_fwd_data;

    // result register
    logic                               r_out_vld;
    logic [lmac_pkg::PC_W-1:0]          r_out_ip;
    logic                               r_out_ov;
    logic [lmac_pkg::BYTE_W-1:0]        r_out_ch;
    lmac_pkg::t_status                  r_out_st;
    logic [lmac_pkg::OUT_ACC_W-1:0]     r_out_acc;

    logic                               exec_go;
    logic                               issue;
    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic [AW-1:0]                      rd_addr;
    logic [lmac_pkg::BYTE_W-1:0]        rd_data;
    logic [lmac_pkg::BYTE_W-1:0]        mem_byte;
    logic [AC-1:0]                      mem_ext;
    logic                               n_ov;
    logic [lmac_pkg::BYTE_W-1:0]        n_ch;
    logic [63:0]                        acc_ext;
    logic [lmac_pkg::PC_W-1:0]          pc_step1;
    logic [lmac_pkg::PC_W-1:0]          pc_step2;
    logic [lmac_pkg::PC_W-1:0]          pc_target;
    logic                               halted;

    assign exec_go = r_ex_vld && (!r_out_vld || !i_stall);
    assign issue   = i_q_vld && (!r_ex_vld || exec_go);
    assign o_q_pop = issue;
    assign halted  = (r_status != lmac_pkg::ST_RUN);

    assign rd_addr = lmac_pkg::ADDR_TAB[i_q_item.arg];
    assign wr_addr = lmac_pkg::ADDR_TAB[r_ex.arg];
    assign wr_en   = exec_go && !halted && (r_ex.op == lmac_pkg::OP_STA);

    lmac_ram #(
        .WIDTH (lmac_pkg::BYTE_W),
        .DEPTH (lmac_pkg::DATA_DEPTH)
    ) u_dmem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_acc[lmac_pkg::BYTE_W-1:0]),
        .i_rd_en   (issue),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // a store retiring in the issue cycle bypasses the ram read
    assign mem_byte = r_fwd_hit ? r_fwd_data : (r_rd_vld ? rd_data : '0);
    assign mem_ext  = AC'(signed'(mem_byte));

    assign pc_step1  = r_pc + lmac_pkg::PC_W'(1);
    assign pc_step2  = r_pc + lmac_pkg::PC_W'(2);
    assign pc_target = lmac_pkg::PC_W'(r_ex.arg);

    always_comb begin
        n_pc     = r_pc;
        n_acc    = r_acc;
        n_status = r_status;
        n_ov     = 1'b0;
        n_ch     = '0;
        if (!halted) begin
            case (r_ex.op)
                lmac_pkg::OP_HLT: begin
                    n_status = lmac_pkg::ST_HALT;
                end
                lmac_pkg::OP_ADD: begin
                    n_acc = r_acc + mem_ext;
                    n_pc  = pc_step2;
                end
                lmac_pkg::OP_SUB: begin
                    n_acc = r_acc - mem_ext;
                    n_pc  = pc_step2;
                end
                lmac_pkg::OP_STA: begin
                    n_pc = pc_step2;
                end
                lmac_pkg::OP_LDA: begin
                    n_acc = mem_ext;
                    n_pc  = pc_step2;
                end
                lmac_pkg::OP_BRA: begin
                    n_pc = pc_target;
                end
                lmac_pkg::OP_BRZ: begin
                    n_pc = (r_acc == '0) ? pc_target : pc_step2;
                end
                lmac_pkg::OP_BRP: begin
                    n_pc = ((r_acc != '0) && !r_acc[AC-1]) ? pc_target : pc_step2;
                end
                lmac_pkg::OP_INP: begin
                    n_acc = AC'(r_ex.chr);
                    n_pc  = pc_step1;
                end
                lmac_pkg::OP_OUT: begin
                    n_ov = 1'b1;
                    n_ch = r_acc[lmac_pkg::BYTE_W-1:0];
                    n_pc = pc_step1;
                end
                default: begin
                    n_status = lmac_pkg::ST_ILLEGAL;
                end
            endcase
        end
    end

    assign acc_ext = 64'(signed'(n_acc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_acc     <= '0;
            r_status  <= lmac_pkg::ST_RUN;
            r_vld     <= '0;
            r_ex_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (exec_go) begin
                r_pc     <= n_pc;
                r_acc    <= n_acc;
                r_status <= n_status;
            end
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (issue) begin
                r_ex_vld <= 1'b1;
            end else if (exec_go) begin
                r_ex_vld <= 1'b0;
            end
            if (exec_go) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_ex       <= i_q_item;
            r_rd_vld   <= r_vld[rd_addr];
            r_fwd_hit  <= wr_en && (wr_addr == rd_addr);
            r_fwd_data <= r_acc[lmac_pkg::BYTE_W-1:0];
        end
        if (exec_go) begin
            r_out_ip  <= n_pc;
            r_out_ov  <= n_ov;
            r_out_ch  <= n_ch;
            r_out_st  <= n_status;
            r_out_acc <= acc_ext[lmac_pkg::OUT_ACC_W-1:0];
        end
    end

    assign o_valid     = r_out_vld;
    assign o_next_ip   = r_out_ip;
    assign o_out_valid = r_out_ov;
    assign o_out_char  = r_out_ch;
    assign o_status    = r_out_st;
    assign o_acc_value = r_out_acc;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        halted |=> r_status == $past(r_status))
        else $error("halt status changed while halted");

    a_char_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_ov |-> r_out_st == lmac_pkg::ST_RUN)
        else $error("character emitted by a halted machine");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_vld)
        else $error("queue popped while empty");

    a_ex_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ex_vld && !exec_go |=> r_ex_vld && $stable(r_ex) && $stable(r_pc))
        else $error("execute stage changed while blocked");

endmodule

// ===== src/little_man_accumulator_cpu.sv =====
`timescale 1ns / 1ps
// little man computer style accumulator machine, one instruction per item
//
// input channel: i_valid / o_stall carry an instruction item (opcode byte,
// operand byte, pending input character); a transfer happens on a rising
// edge with i_valid high and o_stall low. output channel: o_valid / i_stall
// carry one result per item (next fetch address, output character flag and
// value, status, accumulator); a transfer happens with o_valid high and
// i_stall low.
// an item passes through the queue, the execute stage and the result register
// before it can transfer out. throughput: one item per cycle while i_stall stays low,
// set by the single execute stage and its one data memory read per item.
// a two-entry queue separates decode from execute; a stalled receiver fills
// the result register, then the execute stage, then the queue, after which
// o_stall rises. results are never dropped or repeated.
// reset (synchronous, active low) clears program counter, accumulator and
// halt status, and marks all 256 data bytes as zero at once through per-byte
// valid bits; no clearing pass, items are taken the cycle after reset.
module little_man_accumulator_cpu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_opcode,
    input  logic [7:0]  i_operand_byte,
    input  logic [7:0]  i_in_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_next_ip,
    output logic        o_out_valid,
    output logic [7:0]  o_out_char,
    output logic [1:0]  o_status,
    output logic [31:0] o_acc_value
);

    logic             q_vld;
    lmac_pkg::t_instr q_item;
    logic             q_pop;

    lmac_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_operand_byte (i_operand_byte),
        .i_in_char      (i_in_char),
        .o_q_vld        (q_vld),
        .o_q_item       (q_item),
        .i_q_pop        (q_pop)
    );

    lmac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_vld     (q_vld),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_next_ip   (o_next_ip),
        .o_out_valid (o_out_valid),
        .o_out_char  (o_out_char),
        .o_status    (o_status),
        .o_acc_value (o_acc_value)
    );

endmodule

// ===== dv/little_man_accumulator_cpu_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the accumulator machine: predicted results vs dut output
module little_man_accumulator_cpu_tb;

    localparam int CYCLE_LIMIT = 500_000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [15:0]       next_ip;
        logic              out_valid;
        logic [7:0]        out_char;
        lmac_pkg::t_status status;
        logic [31:0]       acc_value;
    } t_step_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_opcode;
    logic [7:0]  i_operand_byte;
    logic [7:0]  i_in_char;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_next_ip;
    logic        o_out_valid;
    logic [7:0]  o_out_char;
    logic [1:0]  o_status;
    logic [31:0] o_acc_value;

    // machine state as the predictor sees it
    logic [15:0]        model_pc;
    logic signed [31:0] model_acc;
    logic [7:0]         model_mem [lmac_pkg::DATA_DEPTH];
    logic               model_halted;
    lmac_pkg::t_status  model_cause;

    t_step_result pending_results [$];
    int gap_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int result_count = 0;
    int cycle_count = 0;

    little_man_accumulator_cpu dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_operand_byte (i_operand_byte),
        .i_in_char      (i_in_char),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_next_ip      (o_next_ip),
        .o_out_valid    (o_out_valid),
        .o_out_char     (o_out_char),
        .o_status       (o_status),
        .o_acc_value    (o_acc_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99, 0) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("little_man_accumulator_cpu: mismatch");
            $finish;
        end
    end

    // executes one instruction on the predictor state and queues its result
    function automatic void exec_instr(input logic [7:0] opc, input logic [7:0] arg,
                                       input logic [7:0] chr);
        t_step_result       r;
        int                 addr;
        logic signed [31:0] mval;
        addr = arg % lmac_pkg::DATA_DEPTH;
        mval = {{24{model_mem[addr][7]}}, model_mem[addr]};
        r.out_valid = 1'b0;
        r.out_char  = 8'd0;
        if (!model_halted) begin
            if (opc > lmac_pkg::OP_OUT) begin
                model_halted = 1'b1;
                model_cause  = lmac_pkg::ST_ILLEGAL;
            end else begin
                case (lmac_pkg::t_op'(opc[3:0]))
                    lmac_pkg::OP_HLT: begin
                        model_halted = 1'b1;
                        model_cause  = lmac_pkg::ST_HALT;
                    end
                    lmac_pkg::OP_ADD: begin
                        model_acc = model_acc + mval;
                        model_pc  = model_pc + 16'd2;
                    end
                    lmac_pkg::OP_SUB: begin
                        model_acc = model_acc - mval;
                        model_pc  = model_pc + 16'd2;
                    end
                    lmac_pkg::OP_STA: begin
                        model_mem[addr] = model_acc[7:0];
                        model_pc = model_pc + 16'd2;
                    end
                    lmac_pkg::OP_LDA: begin
                        model_acc = mval;
                        model_pc  = model_pc + 16'd2;
                    end
                    lmac_pkg::OP_BRA: model_pc = {8'd0, arg};
                    lmac_pkg::OP_BRZ: begin
                        model_pc = (model_acc == 0) ? {8'd0, arg} : model_pc + 16'd2;
                    end
                    lmac_pkg::OP_BRP: begin
                        model_pc = (model_acc > 0) ? {8'd0, arg} : model_pc + 16'd2;
                    end
                    lmac_pkg::OP_INP: begin
                        model_acc = {24'd0, chr};
                        model_pc  = model_pc + 16'd1;
                    end
                    lmac_pkg::OP_OUT: begin
                        r.out_valid = 1'b1;
                        r.out_char  = model_acc[7:0];
                        model_pc    = model_pc + 16'd1;
                    end
                    default: ;
                endcase
            end
        end
        r.next_ip   = model_pc;
        r.status    = model_halted ? model_cause : lmac_pkg::ST_RUN;
        r.acc_value = model_acc;
        pending_results.push_back(r);
    endfunction

    // call at a falling edge, returns at the falling edge after the transfer
    task automatic send_instr(input logic [7:0] opc, input logic [7:0] arg,
                              input logic [7:0] chr);
        while ($urandom_range(99, 0) < gap_pct) @(negedge i_clk);
        i_valid        = 1'b1;
        i_opcode       = opc;
        i_operand_byte = arg;
        i_in_char      = chr;
        do @(posedge i_clk); while (o_stall);
        exec_instr(opc, arg, chr);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // half the addresses from a small pool so stores get read back
    function automatic logic [7:0] pick_addr();
        case ($urandom_range(3, 0))
            0, 1:    return 8'($urandom_range(7, 0));
            2:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(5, 0))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h80;
            3:       return 8'h7f;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("error: result %0d %s expected %h actual %h",
                         result_count, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_step_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("error: unexpected result, next_ip %h acc %h",
                             o_next_ip, o_acc_value);
            end else begin
                want = pending_results.pop_front();
                report_field("next_ip", 32'(want.next_ip), 32'(o_next_ip));
                report_field("out_valid", 32'(want.out_valid), 32'(o_out_valid));
                report_field("out_char", 32'(want.out_char), 32'(o_out_char));
                report_field("status", 32'(want.status), 32'(o_status));
                report_field("acc_value", want.acc_value, o_acc_value);
            end
            result_count++;
        end
    end

    // sign extension, branch edges, extreme addresses and characters
    task automatic test_directed();
        send_instr(lmac_pkg::OP_INP, 8'h00, 8'hff);
        send_instr(lmac_pkg::OP_STA, 8'h00, 8'h00);
        send_instr(lmac_pkg::OP_LDA, 8'h00, 8'h00);
        send_instr(lmac_pkg::OP_OUT, 8'hff, 8'hff);
        send_instr(lmac_pkg::OP_BRP, 8'h10, 8'h00);
        send_instr(lmac_pkg::OP_ADD, 8'h00, 8'h00);
        send_instr(lmac_pkg::OP_INP, 8'h00, 8'h80);
        send_instr(lmac_pkg::OP_STA, 8'hff, 8'h00);
        send_instr(lmac_pkg::OP_INP, 8'hff, 8'h00);
        send_instr(lmac_pkg::OP_BRZ, 8'h20, 8'hff);
        send_instr(lmac_pkg::OP_BRP, 8'h30, 8'h00);
        send_instr(lmac_pkg::OP_INP, 8'h00, 8'h7f);
        send_instr(lmac_pkg::OP_BRP, 8'hff, 8'h00);
        send_instr(lmac_pkg::OP_SUB, 8'hff, 8'h00);
        send_instr(lmac_pkg::OP_ADD, 8'h01, 8'h00);
        send_instr(lmac_pkg::OP_LDA, 8'hff, 8'h00);
        send_instr(lmac_pkg::OP_OUT, 8'h00, 8'h00);
        send_instr(lmac_pkg::OP_BRZ, 8'h00, 8'h00);
        send_instr(lmac_pkg::OP_BRA, 8'h00, 8'hff);
        send_instr(lmac_pkg::OP_LDA, 8'h05, 8'h00);
        send_instr(lmac_pkg::OP_STA, 8'h05, 8'h00);
        send_instr(lmac_pkg::OP_OUT, 8'h00, 8'h00);
        send_instr(lmac_pkg::OP_SUB, 8'hff, 8'h00);
        send_instr(lmac_pkg::OP_BRA, 8'hff, 8'h00);
    endtask

    // short instruction sequences with random content, mixed with lone instructions
    task automatic test_random_programs(input int n_items);
        int          sent;
        logic [7:0]  addr;
        logic [7:0]  target;
        sent = 0;
        while (sent < n_items) begin
            addr   = pick_addr();
            target = 8'($urandom);
            case ($urandom_range(9, 0))
                0: begin
                    // acc minus itself, then a taken zero branch
                    send_instr(lmac_pkg::OP_LDA, addr, 8'($urandom));
                    send_instr(lmac_pkg::OP_SUB, addr, 8'($urandom));
                    send_instr(lmac_pkg::OP_BRZ, target, 8'($urandom));
                    sent += 3;
                end
                1: begin
                    send_instr(lmac_pkg::OP_INP, 8'($urandom), pick_char());
                    send_instr(lmac_pkg::OP_STA, addr, 8'($urandom));
                    send_instr(lmac_pkg::OP_LDA, addr, 8'($urandom));
                    send_instr(lmac_pkg::OP_OUT, 8'($urandom), 8'($urandom));
                    sent += 4;
                end
                2: begin
                    send_instr(lmac_pkg::OP_LDA, addr, 8'($urandom));
                    send_instr(lmac_pkg::OP_ADD, pick_addr(), 8'($urandom));
                    send_instr(lmac_pkg::OP_BRP, target, 8'($urandom));
                    sent += 3;
                end
                default: begin
                    send_instr(8'($urandom_range(lmac_pkg::OP_OUT, lmac_pkg::OP_ADD)), addr,
                               pick_char());
                    sent++;
                end
            endcase
        end
    endtask

    // straight-line code from the top of the branch range, program counter past one byte
    task automatic test_pc_run();
        logic [7:0]  opc;
        send_instr(lmac_pkg::OP_BRA, 8'hff, 8'h00);
        repeat (40) begin
            if ($urandom_range(3, 0) != 0)
                opc = 8'($urandom_range(lmac_pkg::OP_LDA, lmac_pkg::OP_ADD));
            else
                opc = 8'($urandom_range(lmac_pkg::OP_OUT, lmac_pkg::OP_INP));
            send_instr(opc, pick_addr(), pick_char());
        end
        send_instr(lmac_pkg::OP_OUT, 8'($urandom), 8'($urandom));
    endtask

    // the machine stops for good, later transfers only repeat its state
    task automatic test_halt_and_ignore();
        logic [7:0] stop_op;
        if ($urandom_range(1, 0) != 0)
            stop_op = 8'(lmac_pkg::OP_HLT);
        else
            stop_op = 8'($urandom_range(255, lmac_pkg::OP_ILL));
        send_instr(stop_op, 8'($urandom), 8'($urandom));
        send_instr(lmac_pkg::OP_INP, 8'h00, 8'hff);
        send_instr(lmac_pkg::OP_OUT, 8'h00, 8'h00);
        repeat (24) send_instr(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_opcode       = 8'd0;
        i_operand_byte = 8'd0;
        i_in_char      = 8'd0;
        model_pc       = 16'd0;
        model_acc      = 32'sd0;
        model_halted   = 1'b0;
        model_cause    = lmac_pkg::ST_RUN;
        foreach (model_mem[k]) model_mem[k] = 8'd0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        gap_pct   = 29;
        stall_pct = 88;
        test_directed();
        test_random_programs(300);
        wait_drained();

        gap_pct   = 88;
        stall_pct = 29;
        test_random_programs(300);
        wait_drained();

        gap_pct   = 0;
        stall_pct = 0;
        test_random_programs(280);
        test_pc_run();
        test_halt_and_ignore();
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("little_man_accumulator_cpu: match");
        else
            $display("little_man_accumulator_cpu: mismatch");
        $finish;
    end

endmodule
